// ----- rtl/core/wrds_pkg.sv -----
// Shared types and constants for the watched rectangle difference scanner.
// No dependencies; every other file of the block imports it.
package wrds_pkg;

	localparam int MAX_SIDE    = 4;
	localparam int COORD_BITS  = 12;
	localparam int MAX_RESULTS = 32;

	localparam int FIELD_BITS = 12;
	localparam int CELL_BITS  = 13;
	localparam int SIDE_BITS  = 3;
	localparam int CNT_BITS   = $clog2(MAX_RESULTS + 1);

	localparam logic [FIELD_BITS-1:0] COORD_MASK = (COORD_BITS >= FIELD_BITS) ?
		{FIELD_BITS{1'b1}} : FIELD_BITS'((1 << COORD_BITS) - 1);
	localparam logic [SIDE_BITS-1:0] SIDE_MAX = SIDE_BITS'(MAX_SIDE);
	localparam logic [CNT_BITS-1:0]  CNT_MAX  = CNT_BITS'(MAX_RESULTS);

	localparam logic ACT_STOP  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef struct packed {
		logic [FIELD_BITS-1:0] left;
		logic [FIELD_BITS-1:0] top;
		logic [SIDE_BITS-1:0]  width;
		logic [SIDE_BITS-1:0]  height;
	} in_t;

	typedef struct packed {
		logic                 action;
		logic [CELL_BITS-1:0] cell_x;
		logic [CELL_BITS-1:0] cell_y;
		logic                 last;
	} out_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] l;
		logic [FIELD_BITS-1:0] t;
		logic [SIDE_BITS-1:0]  w;
		logic [SIDE_BITS-1:0]  h;
	} rect_t;

	// sequencer -> output stage
	typedef struct packed {
		logic capture;
		logic finish;
	} ostage_ctl_t;

	// output stage -> sequencer
	typedef struct packed {
		logic pend_v;
		logic out_free;
	} ostage_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STOP,
		ST_START,
		ST_FLUSH
	} state_t;

	function automatic logic [SIDE_BITS-1:0] side_sat(input logic [SIDE_BITS-1:0] s);
		return (s > SIDE_MAX) ? SIDE_MAX : s;
	endfunction

endpackage

// ----- rtl/core/watch_rectangle_diff_scan.sv -----
// Watched rectangle difference scanner, top level. Uses wrds_pkg, wrds_seq, wrds_out.
// A result waits in the pending slot for the next result cell or the end of the scan;
// the last one of a request is offered after the flush.
// A new request is taken only once the previous one is fully answered; the scan runs
// through the single compare unit and is held back by output stalls.
// Reset: previous rectangle is empty at the origin, no result pending.
module watch_rectangle_diff_scan import wrds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	ostage_ctl_t octl;
	ostage_sts_t ost;
	out_t        cap_data;
	logic        busy;

	assign in_stall = busy;

	wrds_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.busy     (busy),
		.ost      (ost),
		.octl     (octl),
		.cap_data (cap_data)
	);

	wrds_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (octl),
		.cap_data  (cap_data),
		.sts       (ost),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/core/wrds_cell_unit.sv -----
// Shared cell unit: forms the current cell of rectangle A from its offsets
// and tests it against rectangle B. Uses wrds_pkg.
module wrds_cell_unit import wrds_pkg::*; (
	input  rect_t                a_rect,
	input  rect_t                b_rect,
	input  logic [SIDE_BITS-1:0] col,
	input  logic [SIDE_BITS-1:0] row,
	output logic [CELL_BITS-1:0] cell_x,
	output logic [CELL_BITS-1:0] cell_y,
	output logic                 in_b
);

	logic [CELL_BITS-1:0] b_x0, b_y0, b_x1, b_y1;

	always_comb begin
		cell_x = {1'b0, a_rect.l} + CELL_BITS'(col);
		cell_y = {1'b0, a_rect.t} + CELL_BITS'(row);
		b_x0   = {1'b0, b_rect.l};
		b_y0   = {1'b0, b_rect.t};
		b_x1   = b_x0 + CELL_BITS'(b_rect.w);
		b_y1   = b_y0 + CELL_BITS'(b_rect.h);
		in_b   = (cell_x >= b_x0) && (cell_x < b_x1) && (cell_y >= b_y0) && (cell_y < b_y1);
	end

endmodule

// ----- rtl/core/wrds_seq.sv -----
// Scan sequencer: holds the old and new rectangles and steps one cell per cycle
// via the cell unit unless a hit awaits output room; drives octl. Uses wrds_pkg.
module wrds_seq import wrds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  in_t         in_data,
	output logic        busy,
	input  ostage_sts_t ost,
	output ostage_ctl_t octl,
	output out_t        cap_data
);

	state_t state_q, state_nx;
	rect_t  prev_q, cur_q, a_rect, b_rect;
	logic [SIDE_BITS-1:0] col_q, row_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CELL_BITS-1:0] cell_x, cell_y;
	logic in_b, scanning, cell_exists, at_cap, hit, adv, col_end, row_end, phase_done;

	assign a_rect = (state_q == ST_START) ? cur_q : prev_q;
	assign b_rect = (state_q == ST_START) ? prev_q : cur_q;

	wrds_cell_unit u_cell (
		.a_rect (a_rect),
		.b_rect (b_rect),
		.col    (col_q),
		.row    (row_q),
		.cell_x (cell_x),
		.cell_y (cell_y),
		.in_b   (in_b)
	);

	always_comb begin
		scanning    = (state_q == ST_STOP) || (state_q == ST_START);
		cell_exists = (a_rect.w != '0) && (a_rect.h != '0);
		at_cap      = (cnt_q == CNT_MAX);
		hit         = scanning && cell_exists && !at_cap && !in_b;
		// a hit can only move on if the pending slot is empty or can spill
		adv         = !hit || !ost.pend_v || ost.out_free;
		col_end     = (SIDE_BITS'(col_q + 1'b1) == a_rect.w);
		row_end     = (SIDE_BITS'(row_q + 1'b1) == a_rect.h);
		phase_done  = scanning && (at_cap || !cell_exists || (adv && col_end && row_end));
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_STOP;
			end
			ST_STOP: begin
				if (phase_done) state_nx = ST_START;
			end
			ST_START: begin
				if (phase_done) state_nx = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!ost.pend_v || ost.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = (state_q != ST_IDLE);
		octl.capture    = hit && adv;
		octl.finish     = (state_q == ST_FLUSH) && ost.pend_v && ost.out_free;
		cap_data.action = (state_q == ST_START) ? ACT_START : ACT_STOP;
		cap_data.cell_x = cell_x;
		cap_data.cell_y = cell_y;
		cap_data.last   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			cur_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && in_valid) begin
				cur_q.l <= in_data.left & COORD_MASK;
				cur_q.t <= in_data.top & COORD_MASK;
				cur_q.w <= side_sat(in_data.width);
				cur_q.h <= side_sat(in_data.height);
				col_q   <= '0;
				row_q   <= '0;
				cnt_q   <= '0;
			end else if (scanning) begin
				if (phase_done) begin
					col_q <= '0;
					row_q <= '0;
				end else if (adv) begin
					if (col_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				if (octl.capture) cnt_q <= cnt_q + 1'b1;
			end
			// commit the new rectangle once the request is fully answered
			if (state_q == ST_FLUSH && state_nx == ST_IDLE) prev_q <= cur_q;
		end
	end

endmodule

// ----- rtl/core/wrds_out.sv -----
// Output stage: one pending result held back until the next one (or the end
// of the scan) settles its last flag, then an output register. Uses wrds_pkg.
module wrds_out import wrds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ostage_ctl_t ctl,
	input  out_t        cap_data,
	output ostage_sts_t sts,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	out_t pend_q, out_q;
	logic pend_v_q, out_v_q;

	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_v_q || !out_stall;
	assign out_valid    = out_v_q;
	assign out_data     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
				else if (!out_stall) out_v_q <= 1'b0;
			end else if (ctl.finish) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			pend_q <= cap_data;
			if (pend_v_q)
				out_q <= {pend_q.action, pend_q.cell_x, pend_q.cell_y, 1'b0};
		end else if (ctl.finish) begin
			out_q <= {pend_q.action, pend_q.cell_x, pend_q.cell_y, 1'b1};
		end
	end

endmodule
